[src/ypcam_pkg.sv]
// Shared types, constants and helpers of the yaw/pitch camera view-matrix block.
package ypcam_pkg;

   localparam int POS_W       = 32;
   localparam int HEAD_W      = 17;
   localparam int ELEV_W      = 16;
   localparam int TURN_W      = 18;
   localparam int TRIG_W      = 18;
   localparam int CXY_W       = 33;
   localparam int CZ_W        = 29;
   localparam int PROD_W      = TRIG_W + POS_W;
   localparam int Q_W         = PROD_W - 16;
   localparam int ACC_W       = Q_W + 2;
   localparam int CORDIC_STEPS = 18;

   localparam logic signed [18:0] FULL_TURN  = 19'sd92160;
   localparam logic signed [18:0] HALF_TURN  = 19'sd46080;
   localparam logic signed [18:0] QUARTER    = 19'sd23040;
   localparam logic signed [18:0] PITCH_LIM  = 19'sd22784;
   localparam logic signed [CXY_W-1:0] CORDIC_X0 = 33'sd652032874;

   localparam logic [2:0] CSR_START_X = 3'd0;
   localparam logic [2:0] CSR_START_Y = 3'd1;
   localparam logic [2:0] CSR_START_Z = 3'd2;
   localparam logic [2:0] CSR_START_H = 3'd3;
   localparam logic [2:0] CSR_START_E = 3'd4;

   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_NDIR  = 2'd2;
   localparam logic [1:0] ROW_POS   = 2'd3;

   localparam logic [3:0] OP_U0  = 4'd0;
   localparam logic [3:0] OP_U2  = 4'd1;
   localparam logic [3:0] OP_F0  = 4'd2;
   localparam logic [3:0] OP_F2  = 4'd3;
   localparam logic [3:0] OP_DR0 = 4'd4;
   localparam logic [3:0] OP_DR1 = 4'd5;
   localparam logic [3:0] OP_DR2 = 4'd6;
   localparam logic [3:0] OP_DU0 = 4'd7;
   localparam logic [3:0] OP_DU1 = 4'd8;
   localparam logic [3:0] OP_DU2 = 4'd9;
   localparam logic [3:0] OP_DF0 = 4'd10;
   localparam logic [3:0] OP_DF1 = 4'd11;
   localparam logic [3:0] OP_DF2 = 4'd12;

   typedef struct packed {
      logic       pose_load;
      logic       cor_init;
      logic       cor_step;
      logic       cor_store;
      logic       cor_sel;
      logic [4:0] iter;
      logic       mul_go;
      logic       mul_apply;
      logic [3:0] op;
      logic       out_load;
      logic [1:0] row;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic signed [CZ_W-1:0] atan_deg(input logic [4:0] i);
      logic signed [CZ_W-1:0] v;
      case (i)
         5'd0:    v = 29'sd47185920;
         5'd1:    v = 29'sd27855475;
         5'd2:    v = 29'sd14718068;
         5'd3:    v = 29'sd7471121;
         5'd4:    v = 29'sd3750058;
         5'd5:    v = 29'sd1876857;
         5'd6:    v = 29'sd938658;
         5'd7:    v = 29'sd469358;
         5'd8:    v = 29'sd234682;
         5'd9:    v = 29'sd117342;
         5'd10:   v = 29'sd58671;
         5'd11:   v = 29'sd29335;
         5'd12:   v = 29'sd14668;
         5'd13:   v = 29'sd7334;
         5'd14:   v = 29'sd3667;
         5'd15:   v = 29'sd1833;
         5'd16:   v = 29'sd917;
         5'd17:   v = 29'sd458;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W:0] v);
      logic signed [31:0] r;
      if (v > $signed({{(ACC_W-31){1'b0}}, 32'h7fffffff}))
         r = 32'sh7fffffff;
      else if (v < $signed({{(ACC_W-31){1'b1}}, 32'h80000000}))
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

[src/ypcam_ctrl.sv]
// Sequencer of the camera block: pose update, two sine/cosine runs, products, row output.
module ypcam_ctrl import ypcam_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CORH = 3'd1;
   localparam logic [2:0] S_CORE = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam logic [4:0] COR_LAST = 5'(CORDIC_STEPS + 1);
   localparam logic [4:0] MUL_LAST = 5'd25;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.iter = cnt_ff - 5'd1;
      cmd.op   = cnt_ff[4:1];
      cmd.row  = cnt_ff[1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.pose_load = 1'b1;
               state_in = S_CORH;
               cnt_in   = '0;
            end
         end
         S_CORH, S_CORE: begin
            cmd.cor_sel = (state_ff == S_CORE);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd0) begin
               cmd.cor_init = 1'b1;
            end else if (cnt_ff == COR_LAST) begin
               cmd.cor_store = 1'b1;
               cnt_in   = '0;
               state_in = (state_ff == S_CORH) ? S_CORE : S_MUL;
            end else begin
               cmd.cor_step = 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul_go    = ~cnt_ff[0];
            cmd.mul_apply = cnt_ff[0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff[1:0] == ROW_POS)
                  state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[src/ypcam_dp.sv]
// Datapath of the camera block: pose registers, CORDIC unit, shared multiplier, output register.
module ypcam_dp import ypcam_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data,
   input  logic                       req_restart,
   input  logic signed [POS_W-1:0]    req_move_x,
   input  logic signed [POS_W-1:0]    req_move_y,
   input  logic signed [POS_W-1:0]    req_move_z,
   input  logic signed [TURN_W-1:0]   req_turn_yaw,
   input  logic signed [TURN_W-1:0]   req_turn_pitch,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_row_kind,
   output logic signed [31:0]         rsp_col_a,
   output logic signed [31:0]         rsp_col_b,
   output logic signed [31:0]         rsp_col_c,
   output logic signed [31:0]         rsp_col_d,
   output logic                       rsp_last
);

   logic signed [POS_W-1:0]  cfg_pos_ff [3];
   logic [HEAD_W-1:0]        cfg_head_ff;
   logic signed [ELEV_W-1:0] cfg_elev_ff;

   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [POS_W-1:0]  pos_in [3];
   logic [HEAD_W-1:0]        head_ff, head_in;
   logic signed [ELEV_W-1:0] elev_ff, elev_in;

   logic signed [POS_W-1:0] move [3];
   logic signed [POS_W:0]   psum;
   logic signed [18:0]      hsum, esum;

   assign move[0] = req_move_x;
   assign move[1] = req_move_y;
   assign move[2] = req_move_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pos_ff[0] <= '0;
         cfg_pos_ff[1] <= '0;
         cfg_pos_ff[2] <= '0;
         cfg_head_ff   <= '0;
         cfg_elev_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_X: cfg_pos_ff[0] <= csr_data;
            CSR_START_Y: cfg_pos_ff[1] <= csr_data;
            CSR_START_Z: cfg_pos_ff[2] <= csr_data;
            CSR_START_H: cfg_head_ff   <= csr_data[HEAD_W-1:0];
            CSR_START_E: cfg_elev_ff   <= csr_data[ELEV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psum = {pos_ff[i][POS_W-1], pos_ff[i]} + {move[i][POS_W-1], move[i]};
         if (req_restart)
            pos_in[i] = cfg_pos_ff[i];
         else if (psum[POS_W] != psum[POS_W-1])
            pos_in[i] = psum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
         else
            pos_in[i] = psum[POS_W-1:0];
      end
      if (req_restart) begin
         hsum = {2'b00, cfg_head_ff};
         esum = {{3{cfg_elev_ff[ELEV_W-1]}}, cfg_elev_ff};
      end else begin
         hsum = $signed({2'b00, head_ff}) + {req_turn_yaw[TURN_W-1], req_turn_yaw};
         esum = {{3{elev_ff[ELEV_W-1]}}, elev_ff} + {req_turn_pitch[TURN_W-1], req_turn_pitch};
      end
      if (hsum < -FULL_TURN)
         hsum = hsum + (FULL_TURN <<< 1);
      else if (hsum < 0)
         hsum = hsum + FULL_TURN;
      else if (hsum >= (FULL_TURN <<< 1))
         hsum = hsum - (FULL_TURN <<< 1);
      else if (hsum >= FULL_TURN)
         hsum = hsum - FULL_TURN;
      head_in = hsum[HEAD_W-1:0];
      if (esum > PITCH_LIM)
         esum = PITCH_LIM;
      else if (esum < -PITCH_LIM)
         esum = -PITCH_LIM;
      elev_in = esum[ELEV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         head_ff   <= '0;
         elev_ff   <= '0;
      end else if (cmd.pose_load) begin
         pos_ff  <= pos_in;
         head_ff <= head_in;
         elev_ff <= elev_in;
      end
   end

   // CORDIC rotation, one step per cycle
   logic signed [CXY_W-1:0]  cx_ff, cy_ff;
   logic signed [CZ_W-1:0]   cz_ff;
   logic                     cneg_ff;
   logic signed [18:0]       ang;
   logic                     aneg;
   logic signed [CXY_W-1:0]  dx, dy, xr, yr;
   logic signed [TRIG_W-1:0] sin_q, cos_q;
   logic signed [TRIG_W-1:0] sy_ff, cyw_ff, sp_ff, cp_ff;

   always_comb begin
      ang  = cmd.cor_sel ? {{3{elev_ff[ELEV_W-1]}}, elev_ff} : {2'b00, head_ff};
      aneg = 1'b0;
      if (ang > HALF_TURN)
         ang = ang - FULL_TURN;
      if (ang > QUARTER) begin
         ang  = HALF_TURN - ang;
         aneg = 1'b1;
      end else if (ang < -QUARTER) begin
         ang  = -HALF_TURN - ang;
         aneg = 1'b1;
      end
      dx = cy_ff >>> cmd.iter;
      dy = cx_ff >>> cmd.iter;
      xr = (cx_ff + 33'sd8192) >>> 14;
      yr = (cy_ff + 33'sd8192) >>> 14;
      if (xr > 33'sd65536)
         xr = 33'sd65536;
      else if (xr < -33'sd65536)
         xr = -33'sd65536;
      if (yr > 33'sd65536)
         yr = 33'sd65536;
      else if (yr < -33'sd65536)
         yr = -33'sd65536;
      sin_q = yr[TRIG_W-1:0];
      cos_q = cneg_ff ? -xr[TRIG_W-1:0] : xr[TRIG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cor_init) begin
         cx_ff   <= CORDIC_X0;
         cy_ff   <= '0;
         cz_ff   <= {{(CZ_W-19){ang[18]}}, ang} <<< 12;
         cneg_ff <= aneg;
      end else if (cmd.cor_step) begin
         if (!cz_ff[CZ_W-1]) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_deg(cmd.iter);
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_deg(cmd.iter);
         end
      end
      if (cmd.cor_store) begin
         if (cmd.cor_sel) begin
            sp_ff <= sin_q;
            cp_ff <= cos_q;
         end else begin
            sy_ff  <= sin_q;
            cyw_ff <= cos_q;
         end
      end
   end

   // shared multiplier for vector products and dot terms
   logic signed [TRIG_W-1:0] ma;
   logic signed [POS_W-1:0]  mb;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [Q_W-1:0]    q;
   logic signed [TRIG_W-1:0] u0_ff, u2_ff, f0_ff, f2_ff;
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic [1:0]               acc_sel;
   logic                     acc_first;

   always_comb begin
      ma        = '0;
      mb        = '0;
      acc_sel   = 2'd0;
      acc_first = 1'b0;
      case (cmd.op)
         OP_U0:  begin ma = cyw_ff; mb = POS_W'(sp_ff); end
         OP_U2:  begin ma = sy_ff;  mb = POS_W'(sp_ff); end
         OP_F0:  begin ma = cyw_ff; mb = POS_W'(cp_ff); end
         OP_F2:  begin ma = sy_ff;  mb = POS_W'(cp_ff); end
         OP_DR0: begin ma = -sy_ff; mb = pos_ff[0]; acc_sel = 2'd0; acc_first = 1'b1; end
         OP_DR1: begin ma = '0;     mb = pos_ff[1]; acc_sel = 2'd0; end
         OP_DR2: begin ma = cyw_ff; mb = pos_ff[2]; acc_sel = 2'd0; end
         OP_DU0: begin ma = u0_ff;  mb = pos_ff[0]; acc_sel = 2'd1; acc_first = 1'b1; end
         OP_DU1: begin ma = cp_ff;  mb = pos_ff[1]; acc_sel = 2'd1; end
         OP_DU2: begin ma = u2_ff;  mb = pos_ff[2]; acc_sel = 2'd1; end
         OP_DF0: begin ma = f0_ff;  mb = pos_ff[0]; acc_sel = 2'd2; acc_first = 1'b1; end
         OP_DF1: begin ma = sp_ff;  mb = pos_ff[1]; acc_sel = 2'd2; end
         OP_DF2: begin ma = f2_ff;  mb = pos_ff[2]; acc_sel = 2'd2; end
         default: ;
      endcase
      q = Q_W'((prod_ff + PROD_W'(32768)) >>> 16);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go)
         prod_ff <= PROD_W'(ma) * PROD_W'(mb);
      if (cmd.mul_apply) begin
         case (cmd.op)
            OP_U0:   u0_ff <= -q[TRIG_W-1:0];
            OP_U2:   u2_ff <= -q[TRIG_W-1:0];
            OP_F0:   f0_ff <= q[TRIG_W-1:0];
            OP_F2:   f2_ff <= q[TRIG_W-1:0];
            default: begin
               if (acc_first)
                  acc_ff[acc_sel] <= ACC_W'(q);
               else
                  acc_ff[acc_sel] <= acc_ff[acc_sel] + ACC_W'(q);
            end
         endcase
      end
   end

   // output register
   logic                     rsp_valid_ff;
   logic [1:0]               kind_ff;
   logic signed [31:0]       a_ff, b_ff, c_ff, d_ff;
   logic signed [31:0]       a_in, b_in, c_in, d_in;
   logic signed [ACC_W:0]    dsel;

   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      a_in = '0;
      b_in = '0;
      c_in = '0;
      dsel = '0;
      case (cmd.row)
         ROW_RIGHT: begin
            a_in = 32'(-sy_ff);
            c_in = 32'(cyw_ff);
            dsel = -{acc_ff[0][ACC_W-1], acc_ff[0]};
         end
         ROW_UP: begin
            a_in = 32'(u0_ff);
            b_in = 32'(cp_ff);
            c_in = 32'(u2_ff);
            dsel = -{acc_ff[1][ACC_W-1], acc_ff[1]};
         end
         ROW_NDIR: begin
            a_in = 32'(-f0_ff);
            b_in = 32'(-sp_ff);
            c_in = 32'(-f2_ff);
            dsel = {acc_ff[2][ACC_W-1], acc_ff[2]};
         end
         default: begin
            a_in = pos_ff[0];
            b_in = pos_ff[1];
            c_in = pos_ff[2];
         end
      endcase
      d_in = sat32(dsel);
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         kind_ff <= cmd.row;
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_kind = kind_ff;
   assign rsp_col_a    = a_ff;
   assign rsp_col_b    = b_ff;
   assign rsp_col_c    = c_ff;
   assign rsp_col_d    = d_ff;
   assign rsp_last     = (kind_ff == ROW_POS);

endmodule

[src/yaw_pitch_camera_view_matrix.sv]
// Top level of the yaw/pitch camera view-matrix block.
// The first row is registered after both CORDIC runs and the products; then one row a cycle
// follows while the output is not stalled. A new request is taken only once all four rows
// are loaded, after two CORDIC runs and 13 passes through the one shared multiplier.
// Reset: synchronous; clears pose, start registers and control, output holds no transfer.
module yaw_pitch_camera_view_matrix import ypcam_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   input  logic signed [31:0]       req_move_x,
   input  logic signed [31:0]       req_move_y,
   input  logic signed [31:0]       req_move_z,
   input  logic signed [17:0]       req_turn_yaw,
   input  logic signed [17:0]       req_turn_pitch,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_row_kind,
   output logic signed [31:0]       rsp_col_a,
   output logic signed [31:0]       rsp_col_b,
   output logic signed [31:0]       rsp_col_c,
   output logic signed [31:0]       rsp_col_d,
   output logic                     rsp_last
);

   cmd_type    cmd;
   status_type status;

   ypcam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ypcam_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_restart    (req_restart),
      .req_move_x     (req_move_x),
      .req_move_y     (req_move_y),
      .req_move_z     (req_move_z),
      .req_turn_yaw   (req_turn_yaw),
      .req_turn_pitch (req_turn_pitch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_kind   (rsp_row_kind),
      .rsp_col_a      (rsp_col_a),
      .rsp_col_b      (rsp_col_b),
      .rsp_col_c      (rsp_col_c),
      .rsp_col_d      (rsp_col_d),
      .rsp_last       (rsp_last)
   );

endmodule
